// ===== src/aop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aop_pkg
// Shared widths, codes and control-word types for the box overlap push-out
// search block.
// ----------------------------------------------------------------------------
package aop_pkg;

    localparam int COORD_W  = 24;            // signed Q15.8 coordinate
    localparam int SIZE_W   = COORD_W - 1;   // unsigned extent
    localparam int SUM_W    = SIZE_W + 1;    // own extent plus other extent
    localparam int T_W      = COORD_W + 2;   // push target and distance
    localparam int DIV_W    = COORD_W + 1;   // dividend and quotient
    localparam int CNT_W    = $clog2(DIV_W);
    localparam int NUM_DIRS = 6;
    localparam int DIR_W    = $clog2(NUM_DIRS);
    localparam int UPC_W    = 4;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SIZE_W-1:0]         size_t;
    typedef logic [UPC_W-1:0]          upc_t;
    typedef logic [DIR_W-1:0]          dir_t;

    // Configuration register indexes (word addresses).
    localparam logic [2:0] REG_OWN_SIZE_X  = 3'd0;
    localparam logic [2:0] REG_OWN_SIZE_Y  = 3'd1;
    localparam logic [2:0] REG_OWN_SIZE_Z  = 3'd2;
    localparam logic [2:0] REG_STEP_AMOUNT = 3'd3;
    localparam logic [2:0] REG_SEARCH_LIM  = 3'd4;

    typedef enum logic [1:0] {
        OUT_CLEAR  = 2'd0,
        OUT_PUSHED = 2'd1,
        OUT_LIMIT  = 2'd2
    } outcome_t;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_CHECK,
        OP_TARGET,
        OP_SETUP,
        OP_DIVSTEP,
        OP_DIVEND,
        OP_COMPARE,
        OP_NEXTDIR,
        OP_DECIDE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_INPUT,
        C_FINISHED,
        C_NO_DIV,
        C_DIV_MORE,
        C_MORE_DIRS,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } ctrl_word_t;

    typedef struct packed {
        logic finished;
        logic no_div;
        logic div_more;
        logic more_dirs;
    } dp_flags_t;

endpackage

// ===== src/aop_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aop_seq
// Microprogram sequencer: step counter, control-word table and conditional
// jump logic.
// ----------------------------------------------------------------------------
module aop_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_busy,
    input  aop_pkg::dp_flags_t  flags,
    output aop_pkg::ctrl_word_t ctrl
);

    localparam aop_pkg::upc_t UPC_WAIT    = 4'd0;
    localparam aop_pkg::upc_t UPC_CHECK   = 4'd1;
    localparam aop_pkg::upc_t UPC_TARGET  = 4'd2;
    localparam aop_pkg::upc_t UPC_SETUP   = 4'd3;
    localparam aop_pkg::upc_t UPC_DIVSTEP = 4'd4;
    localparam aop_pkg::upc_t UPC_DIVEND  = 4'd5;
    localparam aop_pkg::upc_t UPC_COMPARE = 4'd6;
    localparam aop_pkg::upc_t UPC_NEXTDIR = 4'd7;
    localparam aop_pkg::upc_t UPC_DECIDE  = 4'd8;
    localparam aop_pkg::upc_t UPC_EMIT    = 4'd9;

    aop_pkg::upc_t upc_reg;
    aop_pkg::upc_t upc_next;
    logic          take_jump;

    function automatic aop_pkg::ctrl_word_t ucode(input aop_pkg::upc_t addr);
        aop_pkg::ctrl_word_t w;
        unique case (addr)
            UPC_WAIT:    w = '{aop_pkg::OP_LOAD,    aop_pkg::C_NO_INPUT,  UPC_WAIT};
            UPC_CHECK:   w = '{aop_pkg::OP_CHECK,   aop_pkg::C_FINISHED,  UPC_EMIT};
            UPC_TARGET:  w = '{aop_pkg::OP_TARGET,  aop_pkg::C_NEVER,     UPC_WAIT};
            UPC_SETUP:   w = '{aop_pkg::OP_SETUP,   aop_pkg::C_NO_DIV,    UPC_COMPARE};
            UPC_DIVSTEP: w = '{aop_pkg::OP_DIVSTEP, aop_pkg::C_DIV_MORE,  UPC_DIVSTEP};
            UPC_DIVEND:  w = '{aop_pkg::OP_DIVEND,  aop_pkg::C_NEVER,     UPC_WAIT};
            UPC_COMPARE: w = '{aop_pkg::OP_COMPARE, aop_pkg::C_NEVER,     UPC_WAIT};
            UPC_NEXTDIR: w = '{aop_pkg::OP_NEXTDIR, aop_pkg::C_MORE_DIRS, UPC_TARGET};
            UPC_DECIDE:  w = '{aop_pkg::OP_DECIDE,  aop_pkg::C_NEVER,     UPC_WAIT};
            UPC_EMIT:    w = '{aop_pkg::OP_EMIT,    aop_pkg::C_OUT_BUSY,  UPC_EMIT};
            default:     w = '{aop_pkg::OP_LOAD,    aop_pkg::C_NO_INPUT,  UPC_WAIT};
        endcase
        return w;
    endfunction

    always_comb
    begin
        ctrl = ucode(upc_reg);
        unique case (ctrl.cond)
            aop_pkg::C_NEVER:     take_jump = 1'b0;
            aop_pkg::C_NO_INPUT:  take_jump = !in_valid;
            aop_pkg::C_FINISHED:  take_jump = flags.finished;
            aop_pkg::C_NO_DIV:    take_jump = flags.no_div;
            aop_pkg::C_DIV_MORE:  take_jump = flags.div_more;
            aop_pkg::C_MORE_DIRS: take_jump = flags.more_dirs;
            aop_pkg::C_OUT_BUSY:  take_jump = out_busy;
            default:              take_jump = 1'b0;
        endcase
        // The last step of the program falls through to the first.
        if (take_jump)
        begin
            upc_next = ctrl.target;
        end
        else if (upc_reg == UPC_EMIT)
        begin
            upc_next = UPC_WAIT;
        end
        else
        begin
            upc_next = upc_reg + aop_pkg::upc_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UPC_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== src/aop_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aop_dp
// Datapath: box registers, overlap test, push-target arithmetic, a radix-2
// restoring divider and the best-candidate registers.
// ----------------------------------------------------------------------------
module aop_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  aop_pkg::ctrl_word_t ctrl,
    input  logic                load,
    input  aop_pkg::coord_t     own_x,
    input  aop_pkg::coord_t     own_y,
    input  aop_pkg::coord_t     own_z,
    input  aop_pkg::coord_t     other_x,
    input  aop_pkg::coord_t     other_y,
    input  aop_pkg::coord_t     other_z,
    input  aop_pkg::size_t      other_size_x,
    input  aop_pkg::size_t      other_size_y,
    input  aop_pkg::size_t      other_size_z,
    input  aop_pkg::size_t      own_size_x,
    input  aop_pkg::size_t      own_size_y,
    input  aop_pkg::size_t      own_size_z,
    input  aop_pkg::size_t      step_amount,
    input  aop_pkg::size_t      search_limit,
    output aop_pkg::coord_t     res_x,
    output aop_pkg::coord_t     res_y,
    output aop_pkg::coord_t     res_z,
    output aop_pkg::outcome_t   outcome,
    output aop_pkg::dp_flags_t  flags
);

    localparam int COORD_W = aop_pkg::COORD_W;
    localparam int SIZE_W  = aop_pkg::SIZE_W;
    localparam int SUM_W   = aop_pkg::SUM_W;
    localparam int T_W     = aop_pkg::T_W;
    localparam int DIV_W   = aop_pkg::DIV_W;
    localparam int CNT_W   = aop_pkg::CNT_W;

    localparam logic signed [T_W-1:0] T_MAX  = T_W'(2**(COORD_W-1) - 1);
    localparam logic signed [T_W-1:0] T_MIN  = T_W'(-(2**(COORD_W-1)));
    localparam logic signed [T_W-1:0] T_ONE  = T_W'(1);
    localparam logic signed [T_W-1:0] T_ZERO = '0;
    localparam aop_pkg::dir_t LAST_DIR = aop_pkg::dir_t'(aop_pkg::NUM_DIRS - 1);

    // Axis order in the arrays: 0 x, 1 y, 2 z.
    aop_pkg::coord_t   a_reg   [3];
    aop_pkg::coord_t   b_reg   [3];
    aop_pkg::coord_t   res_reg [3];
    logic [SUM_W-1:0]  s_reg   [3];

    aop_pkg::outcome_t outcome_reg;
    aop_pkg::dir_t     dir_reg;
    logic signed [T_W-1:0] t_reg;
    logic              nok_reg;

    logic [SIZE_W-1:0] rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  div_cnt_reg;

    logic              cand_ok_reg;
    logic [DIV_W-1:0]  cand_k_reg;
    logic [DIV_W-1:0]  cand_prod_reg;
    logic              best_ok_reg;
    logic [DIV_W-1:0]  best_k_reg;
    logic [DIV_W-1:0]  best_prod_reg;
    aop_pkg::dir_t     best_dir_reg;

    // Directions run +x, -x, +z, -z, +y, -y; even codes push upwards.
    function automatic logic [1:0] axis_of(input aop_pkg::dir_t d);
        logic [1:0] ax;
        unique case (d[aop_pkg::DIR_W-1:1])
            2'd0:    ax = 2'd0;
            2'd1:    ax = 2'd2;
            2'd2:    ax = 2'd1;
            default: ax = 2'd0;
        endcase
        return ax;
    endfunction

    aop_pkg::dir_t         sel_dir;
    logic [1:0]            sel_axis;
    logic                  positive;
    aop_pkg::coord_t       a_sel;
    aop_pkg::coord_t       b_sel;
    logic [SUM_W-1:0]      s_sel;
    logic signed [T_W-1:0] a_ext;
    logic signed [T_W-1:0] b_ext;
    logic signed [T_W-1:0] half_ext;
    logic signed [T_W-1:0] t_pos;
    logic signed [T_W-1:0] t_neg;
    logic signed [T_W-1:0] push_dist;
    logic                  dist_pos;
    logic [DIV_W-1:0]      dividend;
    logic [SIZE_W:0]       rs;
    logic                  ge;
    logic [SIZE_W:0]       rs_diff;
    logic signed [T_W-1:0] moved;
    aop_pkg::coord_t       moved_sat;
    logic                  push_ok;
    logic signed [COORD_W:0] diff [3];
    logic [COORD_W:0]      mag  [3];
    logic [2:0]            ov;

    always_comb
    begin
        sel_dir   = (ctrl.op == aop_pkg::OP_DECIDE) ? best_dir_reg : dir_reg;
        sel_axis  = axis_of(sel_dir);
        positive  = ~sel_dir[0];
        a_sel     = a_reg[sel_axis];
        b_sel     = b_reg[sel_axis];
        s_sel     = s_reg[sel_axis];
        a_ext     = T_W'(a_sel);
        b_ext     = T_W'(b_sel);
        half_ext  = $signed({3'b000, s_sel[SUM_W-1:1]});
        t_pos     = a_ext + half_ext + T_ONE;
        t_neg     = a_ext - half_ext - T_ONE;
        push_dist = positive ? (t_reg - b_ext) : (b_ext - t_reg);
        dist_pos  = push_dist > T_ZERO;
        // Ceiling division by the step: (push_dist + step - 1) / step.
        dividend  = push_dist[DIV_W-1:0] + DIV_W'(step_amount) - DIV_W'(1);

        rs       = {rem_reg, quo_reg[DIV_W-1]};
        ge       = rs >= {1'b0, step_amount};
        rs_diff  = rs - {1'b0, step_amount};

        push_ok  = best_ok_reg && ((best_k_reg == DIV_W'(1)) ||
                                   (best_prod_reg <= DIV_W'(search_limit)));
        moved    = positive ? (b_ext + $signed({1'b0, best_prod_reg}))
                            : (b_ext - $signed({1'b0, best_prod_reg}));
        if (moved > T_MAX)
        begin
            moved_sat = T_MAX[COORD_W-1:0];
        end
        else if (moved < T_MIN)
        begin
            moved_sat = T_MIN[COORD_W-1:0];
        end
        else
        begin
            moved_sat = moved[COORD_W-1:0];
        end

        for (int i = 0; i < 3; i++)
        begin
            diff[i] = (COORD_W+1)'(a_reg[i]) - (COORD_W+1)'(b_reg[i]);
            mag[i]  = diff[i][COORD_W] ? (~diff[i] + 1'b1) : diff[i];
            ov[i]   = {mag[i], 1'b0} <= {2'b00, s_reg[i]};
        end

        flags.finished  = !(&ov) || (step_amount == '0);
        flags.no_div    = nok_reg || !dist_pos;
        flags.div_more  = div_cnt_reg != '0;
        flags.more_dirs = dir_reg != LAST_DIR;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg[0]   <= own_x;
            a_reg[1]   <= own_y;
            a_reg[2]   <= own_z;
            b_reg[0]   <= other_x;
            b_reg[1]   <= other_y;
            b_reg[2]   <= other_z;
            res_reg[0] <= other_x;
            res_reg[1] <= other_y;
            res_reg[2] <= other_z;
            s_reg[0]   <= SUM_W'(own_size_x) + SUM_W'(other_size_x);
            s_reg[1]   <= SUM_W'(own_size_y) + SUM_W'(other_size_y);
            s_reg[2]   <= SUM_W'(own_size_z) + SUM_W'(other_size_z);
        end
        if (ctrl.op == aop_pkg::OP_DECIDE && push_ok)
        begin
            res_reg[sel_axis] <= moved_sat;
        end
        if (ctrl.op == aop_pkg::OP_TARGET)
        begin
            t_reg <= positive ? t_pos : t_neg;
        end
        if (ctrl.op == aop_pkg::OP_SETUP)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvd_reg <= dividend;
        end
        if (ctrl.op == aop_pkg::OP_DIVSTEP)
        begin
            rem_reg <= ge ? rs_diff[SIZE_W-1:0] : rs[SIZE_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
        if (ctrl.op == aop_pkg::OP_SETUP)
        begin
            cand_k_reg    <= DIV_W'(1);
            cand_prod_reg <= DIV_W'(step_amount);
        end
        else if (ctrl.op == aop_pkg::OP_DIVEND)
        begin
            // quotient * step equals dividend minus remainder.
            cand_k_reg    <= quo_reg;
            cand_prod_reg <= dvd_reg - DIV_W'(rem_reg);
        end
        if (ctrl.op == aop_pkg::OP_COMPARE && cand_ok_reg &&
            (!best_ok_reg || cand_k_reg < best_k_reg))
        begin
            best_k_reg    <= cand_k_reg;
            best_prod_reg <= cand_prod_reg;
            best_dir_reg  <= dir_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outcome_reg <= aop_pkg::OUT_CLEAR;
            dir_reg     <= '0;
            nok_reg     <= 1'b0;
            div_cnt_reg <= '0;
            cand_ok_reg <= 1'b0;
            best_ok_reg <= 1'b0;
        end
        else
        begin
            unique case (ctrl.op)
                aop_pkg::OP_CHECK:
                begin
                    outcome_reg <= (&ov) ? aop_pkg::OUT_LIMIT : aop_pkg::OUT_CLEAR;
                    dir_reg     <= '0;
                    best_ok_reg <= 1'b0;
                end
                aop_pkg::OP_TARGET:
                begin
                    nok_reg <= positive ? (t_pos > T_MAX) : (t_neg < T_MIN);
                end
                aop_pkg::OP_SETUP:
                begin
                    // A target outside the coordinate range can never be reached.
                    cand_ok_reg <= !nok_reg;
                    div_cnt_reg <= CNT_W'(DIV_W - 1);
                end
                aop_pkg::OP_DIVSTEP:
                begin
                    div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                end
                aop_pkg::OP_COMPARE:
                begin
                    if (cand_ok_reg)
                    begin
                        best_ok_reg <= 1'b1;
                    end
                end
                aop_pkg::OP_NEXTDIR:
                begin
                    dir_reg <= dir_reg + aop_pkg::dir_t'(1);
                end
                aop_pkg::OP_DECIDE:
                begin
                    outcome_reg <= push_ok ? aop_pkg::OUT_PUSHED : aop_pkg::OUT_LIMIT;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res_x   = res_reg[0];
    assign res_y   = res_reg[1];
    assign res_z   = res_reg[2];
    assign outcome = outcome_reg;

endmodule

// ===== src/aabb_overlap_pushout_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_overlap_pushout_search
// Box overlap test with push-out search, driven by a microprogram.
// ----------------------------------------------------------------------------
// An item enters on the input channel (in_valid/in_ready) with both box
// centres and the other box's extents; one result leaves on the output
// channel (out_valid/out_ready) with the resolved centre and an outcome code.
// The own box size, step and search limit sit in APB registers, to be written
// while the block is idle; the block itself does not enforce this.
// A pair that does not overlap, or a zero step, goes from the check step
// straight to the emit step. Otherwise the target, setup, compare and
// next-direction steps run for each of the six push directions; between
// setup and compare the restoring divider works out the push count when the
// target is in range and the distance is positive, one quotient bit per cycle.
// One item is worked on at a time; the input is ready again as soon as the
// result sits in the output register, so the next transaction can be taken
// while the receiver stalls. A stalled receiver holds the sequencer at its
// final step only when a second result is ready to be written.
// Reset returns the sequencer to its wait step, empties the output register
// and loads the register defaults.
// ----------------------------------------------------------------------------
module aabb_overlap_pushout_search (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [23:0]             own_x,
    input  logic signed [23:0]             own_y,
    input  logic signed [23:0]             own_z,
    input  logic signed [23:0]             other_x,
    input  logic signed [23:0]             other_y,
    input  logic signed [23:0]             other_z,
    input  logic [22:0]                    other_size_x,
    input  logic [22:0]                    other_size_y,
    input  logic [22:0]                    other_size_z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [23:0]             result_x,
    output logic signed [23:0]             result_y,
    output logic signed [23:0]             result_z,
    output logic [1:0]                     outcome,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aop_pkg::ADDR_W-1:0]     paddr,
    input  logic [aop_pkg::DATA_W-1:0]     pwdata,
    output logic [aop_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    localparam int SIZE_W = aop_pkg::SIZE_W;

    aop_pkg::size_t own_size_x_reg;
    aop_pkg::size_t own_size_y_reg;
    aop_pkg::size_t own_size_z_reg;
    aop_pkg::size_t step_amount_reg;
    aop_pkg::size_t search_limit_reg;

    aop_pkg::ctrl_word_t ctrl;
    aop_pkg::dp_flags_t  flags;
    aop_pkg::coord_t     dp_res_x;
    aop_pkg::coord_t     dp_res_y;
    aop_pkg::coord_t     dp_res_z;
    aop_pkg::outcome_t   dp_outcome;

    logic              out_valid_reg;
    logic              out_valid_next;
    aop_pkg::coord_t   result_x_reg;
    aop_pkg::coord_t   result_y_reg;
    aop_pkg::coord_t   result_z_reg;
    aop_pkg::outcome_t outcome_reg;

    logic              in_fire;
    logic              out_busy;
    logic              emit_fire;
    logic              cfg_write;
    logic [2:0]        reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[aop_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_size_x_reg   <= SIZE_W'(256);
            own_size_y_reg   <= SIZE_W'(256);
            own_size_z_reg   <= SIZE_W'(256);
            step_amount_reg  <= SIZE_W'(3);
            search_limit_reg <= SIZE_W'(10240);
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                aop_pkg::REG_OWN_SIZE_X:  own_size_x_reg   <= pwdata[SIZE_W-1:0];
                aop_pkg::REG_OWN_SIZE_Y:  own_size_y_reg   <= pwdata[SIZE_W-1:0];
                aop_pkg::REG_OWN_SIZE_Z:  own_size_z_reg   <= pwdata[SIZE_W-1:0];
                aop_pkg::REG_STEP_AMOUNT: step_amount_reg  <= pwdata[SIZE_W-1:0];
                aop_pkg::REG_SEARCH_LIM:  search_limit_reg <= pwdata[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            aop_pkg::REG_OWN_SIZE_X:  prdata = aop_pkg::DATA_W'(own_size_x_reg);
            aop_pkg::REG_OWN_SIZE_Y:  prdata = aop_pkg::DATA_W'(own_size_y_reg);
            aop_pkg::REG_OWN_SIZE_Z:  prdata = aop_pkg::DATA_W'(own_size_z_reg);
            aop_pkg::REG_STEP_AMOUNT: prdata = aop_pkg::DATA_W'(step_amount_reg);
            aop_pkg::REG_SEARCH_LIM:  prdata = aop_pkg::DATA_W'(search_limit_reg);
            default:                  prdata = '0;
        endcase
    end

    assign in_ready  = (ctrl.op == aop_pkg::OP_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign out_busy  = out_valid_reg && !out_ready;
    assign emit_fire = (ctrl.op == aop_pkg::OP_EMIT) && !out_busy;

    aop_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .flags    (flags),
        .ctrl     (ctrl)
    );

    aop_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .load         (in_fire),
        .own_x        (own_x),
        .own_y        (own_y),
        .own_z        (own_z),
        .other_x      (other_x),
        .other_y      (other_y),
        .other_z      (other_z),
        .other_size_x (other_size_x),
        .other_size_y (other_size_y),
        .other_size_z (other_size_z),
        .own_size_x   (own_size_x_reg),
        .own_size_y   (own_size_y_reg),
        .own_size_z   (own_size_z_reg),
        .step_amount  (step_amount_reg),
        .search_limit (search_limit_reg),
        .res_x        (dp_res_x),
        .res_y        (dp_res_y),
        .res_z        (dp_res_z),
        .outcome      (dp_outcome),
        .flags        (flags)
    );

    always_comb
    begin
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            result_x_reg <= dp_res_x;
            result_y_reg <= dp_res_y;
            result_z_reg <= dp_res_z;
            outcome_reg  <= dp_outcome;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_x  = result_x_reg;
    assign result_y  = result_y_reg;
    assign result_z  = result_z_reg;
    assign outcome   = outcome_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the box overlap push-out search block.
// A behavioural predictor works out the resolved centre and outcome of each
// accepted box pair from its own copy of the APB registers. A monitor
// compares every returned transaction, field by field, with the oldest
// prediction. Directed pairs cover boundaries, saturation, a zero step and a
// limit below the step. Random pairs, mostly overlapping by construction,
// then run under several register settings, with random idling on both
// channels in all but one of them.
// ----------------------------------------------------------------------------
module tb;

    localparam longint COORD_HI     = (longint'(1) << (aop_pkg::COORD_W - 1)) - 1;
    localparam longint COORD_LO     = -COORD_HI - 1;
    localparam longint SIZE_TOP     = (longint'(1) << aop_pkg::SIZE_W) - 1;
    localparam longint NO_PUSH      = longint'(64'h7fff_ffff_ffff_ffff);
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 250;
    localparam int     PAIRS_PER_SETTING = 20;

    typedef struct packed {
        aop_pkg::coord_t [2:0] own_c;
        aop_pkg::coord_t [2:0] other_c;
        aop_pkg::size_t  [2:0] other_ext;
    } box_pair_t;

    typedef struct packed {
        aop_pkg::coord_t   x;
        aop_pkg::coord_t   y;
        aop_pkg::coord_t   z;
        aop_pkg::outcome_t code;
    } placement_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    aop_pkg::coord_t             own_x, own_y, own_z;
    aop_pkg::coord_t             other_x, other_y, other_z;
    aop_pkg::size_t              other_size_x, other_size_y, other_size_z;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    aop_pkg::coord_t             result_x, result_y, result_z;
    logic [1:0]                  outcome;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [aop_pkg::ADDR_W-1:0]  paddr;
    logic [aop_pkg::DATA_W-1:0]  pwdata;
    logic [aop_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    // Shadow copy of the block's registers, kept in step with every APB write.
    aop_pkg::size_t own_ext [3];
    aop_pkg::size_t push_step;
    aop_pkg::size_t push_limit;

    placement_t pending_placements [$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  clear_seen     = 0;
    int  pushed_seen    = 0;
    int  limit_seen     = 0;
    int  settings_used  = 1;
    int  cycle_count    = 0;
    int  stall_left     = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;

    aabb_overlap_pushout_search u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .own_x        (own_x),
        .own_y        (own_y),
        .own_z        (own_z),
        .other_x      (other_x),
        .other_y      (other_y),
        .other_z      (other_z),
        .other_size_x (other_size_x),
        .other_size_y (other_size_y),
        .other_size_z (other_size_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_x     (result_x),
        .result_y     (result_y),
        .result_z     (result_z),
        .outcome      (outcome),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic longint clamp_coord(input longint v);
        if (v > COORD_HI)
            return COORD_HI;
        if (v < COORD_LO)
            return COORD_LO;
        return v;
    endfunction

    // Push order is +x, -x, +z, -z, +y, -y; even indexes push upwards.
    function automatic int axis_of_dir(input int dir);
        return (dir < 2) ? 0 : ((dir < 4) ? 2 : 1);
    endfunction

    // Fewest steps that carry the other centre clear of the own box in one
    // direction, or NO_PUSH when the clear point lies outside the coordinate range.
    function automatic longint rounds_to_clear(input longint own_c, input longint oth_c,
                                               input longint span, input bit up,
                                               input longint step);
        longint half;
        longint target;
        half = span / 2;
        if (up)
        begin
            target = own_c + half + 1;
            if (target > COORD_HI)
                return NO_PUSH;
            return (target - oth_c <= 0) ? 1 : (target - oth_c + step - 1) / step;
        end
        target = own_c - half - 1;
        if (target < COORD_LO)
            return NO_PUSH;
        return (oth_c - target <= 0) ? 1 : (oth_c - target + step - 1) / step;
    endfunction

    function automatic placement_t resolve_push(input box_pair_t p);
        longint     own_c [3];
        longint     oth_c [3];
        longint     span [3];
        longint     pos [3];
        longint     sep, step, kmax, best, k;
        int         ax, dir, best_dir;
        bit         overlap;
        placement_t r;
        overlap = 1'b1;
        for (ax = 0; ax < 3; ax++)
        begin
            own_c[ax] = longint'($signed(p.own_c[ax]));
            oth_c[ax] = longint'($signed(p.other_c[ax]));
            span[ax]  = longint'(own_ext[ax]) + longint'(p.other_ext[ax]);
            pos[ax]   = oth_c[ax];
            sep       = own_c[ax] - oth_c[ax];
            if (sep < 0)
                sep = -sep;
            if (2 * sep > span[ax])
                overlap = 1'b0;
        end
        if (!overlap)
            r.code = aop_pkg::OUT_CLEAR;
        else if (push_step == 0)
            r.code = aop_pkg::OUT_LIMIT;
        else
        begin
            step     = longint'(push_step);
            kmax     = longint'(push_limit) / step;
            best     = NO_PUSH;
            best_dir = -1;
            // The first round is tried even when the limit is below one step.
            if (kmax < 1)
                kmax = 1;
            for (dir = 0; dir < aop_pkg::NUM_DIRS; dir++)
            begin
                ax = axis_of_dir(dir);
                k  = rounds_to_clear(own_c[ax], oth_c[ax], span[ax], dir % 2 == 0, step);
                if (k < best)
                begin
                    best     = k;
                    best_dir = dir;
                end
            end
            if (best_dir >= 0 && best <= kmax)
            begin
                ax = axis_of_dir(best_dir);
                if (best_dir % 2 == 0)
                    pos[ax] = clamp_coord(oth_c[ax] + best * step);
                else
                    pos[ax] = clamp_coord(oth_c[ax] - best * step);
                r.code = aop_pkg::OUT_PUSHED;
            end
            else
                r.code = aop_pkg::OUT_LIMIT;
        end
        r.x = aop_pkg::coord_t'(pos[0]);
        r.y = aop_pkg::coord_t'(pos[1]);
        r.z = aop_pkg::coord_t'(pos[2]);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic box_pair_t pair_of(input longint ox, input longint oy,
                                          input longint oz, input longint px,
                                          input longint py, input longint pz,
                                          input longint ex, input longint ey,
                                          input longint ez);
        box_pair_t p;
        p.own_c[0]     = aop_pkg::coord_t'(ox);
        p.own_c[1]     = aop_pkg::coord_t'(oy);
        p.own_c[2]     = aop_pkg::coord_t'(oz);
        p.other_c[0]   = aop_pkg::coord_t'(px);
        p.other_c[1]   = aop_pkg::coord_t'(py);
        p.other_c[2]   = aop_pkg::coord_t'(pz);
        p.other_ext[0] = aop_pkg::size_t'(ex);
        p.other_ext[1] = aop_pkg::size_t'(ey);
        p.other_ext[2] = aop_pkg::size_t'(ez);
        return p;
    endfunction

    // Extents spread over every order of magnitude up to the full field.
    function automatic longint pick_size();
        int unsigned scale;
        scale = $urandom_range(0, aop_pkg::SIZE_W);
        if (scale == 0)
            return 0;
        return longint'($urandom_range(0, (1 << scale) - 1));
    endfunction

    function automatic longint pick_centre();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return COORD_HI - longint'($urandom_range(0, 4096));
        if (r == 1)
            return COORD_LO + longint'($urandom_range(0, 4096));
        return longint'($urandom_range(0, 1 << 17)) - (longint'(1) << 16);
    endfunction

    // Offset within the overlap range, with the odd touching or just-clear case.
    function automatic longint pick_offset(input longint span);
        longint      half, mag;
        int unsigned r;
        half = span / 2;
        r    = $urandom_range(0, 19);
        if (r == 0)
            mag = half + 1;
        else if (r == 1)
            mag = half;
        else
            mag = longint'($urandom_range(0, 32'(half)));
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    function automatic box_pair_t random_pair();
        box_pair_t p;
        longint    centre;
        int        ax;
        if ($urandom_range(0, 99) < 15)
        begin
            // Unstructured pairs: every bit of every field toggles.
            for (ax = 0; ax < 3; ax++)
            begin
                p.own_c[ax]     = aop_pkg::coord_t'($urandom);
                p.other_c[ax]   = aop_pkg::coord_t'($urandom);
                p.other_ext[ax] = aop_pkg::size_t'($urandom);
            end
        end
        else
        begin
            for (ax = 0; ax < 3; ax++)
            begin
                p.other_ext[ax] = aop_pkg::size_t'(pick_size());
                centre          = pick_centre();
                p.own_c[ax]     = aop_pkg::coord_t'(centre);
                p.other_c[ax]   = aop_pkg::coord_t'(clamp_coord(centre + pick_offset(
                                      longint'(own_ext[ax]) + longint'(p.other_ext[ax]))));
            end
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Bus tasks; each is entered and left on a rising clock edge.
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input aop_pkg::size_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(aop_pkg::DATA_W - aop_pkg::SIZE_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            aop_pkg::REG_OWN_SIZE_X:  own_ext[0] = value;
            aop_pkg::REG_OWN_SIZE_Y:  own_ext[1] = value;
            aop_pkg::REG_OWN_SIZE_Z:  own_ext[2] = value;
            aop_pkg::REG_STEP_AMOUNT: push_step  = value;
            aop_pkg::REG_SEARCH_LIM:  push_limit = value;
            default: ;
        endcase
    endtask

    task automatic program_setting(input longint sx, input longint sy, input longint sz,
                                   input longint step, input longint limit);
        write_reg(aop_pkg::REG_OWN_SIZE_X,  aop_pkg::size_t'(sx));
        write_reg(aop_pkg::REG_OWN_SIZE_Y,  aop_pkg::size_t'(sy));
        write_reg(aop_pkg::REG_OWN_SIZE_Z,  aop_pkg::size_t'(sz));
        write_reg(aop_pkg::REG_STEP_AMOUNT, aop_pkg::size_t'(step));
        write_reg(aop_pkg::REG_SEARCH_LIM,  aop_pkg::size_t'(limit));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task automatic send_pair(input box_pair_t p);
        int gap;
        gap = tx_idle_on ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        own_x        <= p.own_c[0];
        own_y        <= p.own_c[1];
        own_z        <= p.own_c[2];
        other_x      <= p.other_c[0];
        other_y      <= p.other_c[1];
        other_z      <= p.other_c[2];
        other_size_x <= p.other_ext[0];
        other_size_y <= p.other_ext[1];
        other_size_z <= p.other_ext[2];
        do
            @(posedge clk);
        while (!in_ready);
        pending_placements.push_back(resolve_push(p));
    endtask

    // Lets the block run dry so that the registers may be rewritten.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        // Own box 1.0 wide, step 3, limit 40.0 straight out of reset.
        send_pair(pair_of(0, 0, 0, 1000, 0, 0, 256, 256, 256));
        send_pair(pair_of(0, 0, 0, 256, 0, 0, 256, 256, 256));
        send_pair(pair_of(0, 0, 0, 257, 0, 0, 256, 256, 256));
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 256, 256, 256));
        // Push up x lands past the top of the range and saturates.
        send_pair(pair_of(COORD_HI - 257, 0, 0, COORD_HI - 257, 0, 0, 256, 256, 256));
        // Up x can never clear the box at the top of the range.
        send_pair(pair_of(COORD_HI, 0, 0, COORD_HI, 0, 0, 256, 256, 256));
        send_pair(pair_of(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI,
                          SIZE_TOP, SIZE_TOP, SIZE_TOP));
        send_pair(pair_of(COORD_HI, COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_LO,
                          0, 0, 0));
        send_pair(pair_of(0, 0, 0, 100, -50, 30, 128, 128, 128));
        settle();
    endtask

    task automatic test_wide_boxes();
        program_setting(SIZE_TOP, SIZE_TOP, SIZE_TOP, 1, SIZE_TOP);
        send_pair(pair_of(0, 0, 0, 0, 0, 0, SIZE_TOP, SIZE_TOP, SIZE_TOP));
        send_pair(pair_of(1, 1, 1, 0, 0, 0, SIZE_TOP, SIZE_TOP, SIZE_TOP));
        send_pair(pair_of(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI,
                          SIZE_TOP, SIZE_TOP, SIZE_TOP));
        send_pair(pair_of(COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI,
                          SIZE_TOP, SIZE_TOP, SIZE_TOP));
        settle();
    endtask

    task automatic test_zero_step();
        // With no step the search cannot move, so an overlap stays put.
        program_setting(256, 256, 256, 0, 10240);
        send_pair(pair_of(0, 0, 0, 10, 20, 30, 256, 256, 256));
        send_pair(pair_of(0, 0, 0, 5000, 0, 0, 256, 256, 256));
        settle();
    endtask

    task automatic test_limit_below_step();
        program_setting(256, 256, 256, 1000, 10);
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 256, 256, 256));
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 4000, 4000, 4000));
        settle();
        program_setting(256, 256, 256, 1000, 0);
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 256, 256, 256));
        send_pair(pair_of(0, 0, 0, -3, 7, 0, 4000, 4000, 4000));
        settle();
    endtask

    task automatic test_random_sweep();
        int setting;
        int n;
        for (setting = 0; setting < 5; setting++)
        begin
            tx_idle_on = (setting != 2);
            rx_idle_on = (setting != 2);
            case (setting)
                0: program_setting(256, 256, 256, 3, 10240);
                1: program_setting(pick_size(), pick_size(), pick_size(),
                                   $urandom_range(1, 40), $urandom_range(0, 1 << 16));
                2: program_setting(0, 0, 0, 1, SIZE_TOP);
                3: program_setting(SIZE_TOP, SIZE_TOP, SIZE_TOP, SIZE_TOP, SIZE_TOP);
                default: program_setting(pick_size(), pick_size(), pick_size(),
                                         $urandom_range(1, 1 << 12),
                                         $urandom_range(0, 32'(SIZE_TOP)));
            endcase
            for (n = 0; n < PAIRS_PER_SETTING; n++)
                send_pair(random_pair());
            settle();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Receiver, monitor and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left -= 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    task automatic report_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        placement_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_placements.size() == 0)
            begin
                $display("%0t: unexpected result transaction, got (%0d, %0d, %0d) outcome %0d",
                         $time, result_x, result_y, result_z, outcome);
                mismatch_count++;
            end
            else
            begin
                want = pending_placements.pop_front();
                report_field("result_x", want.x, result_x);
                report_field("result_y", want.y, result_y);
                report_field("result_z", want.z, result_z);
                report_field("outcome", want.code, outcome);
                case (want.code)
                    aop_pkg::OUT_CLEAR:  clear_seen++;
                    aop_pkg::OUT_PUSHED: pushed_seen++;
                    default:             limit_seen++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_placements.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        own_x        = '0;
        own_y        = '0;
        own_z        = '0;
        other_x      = '0;
        other_y      = '0;
        other_z      = '0;
        other_size_x = '0;
        other_size_y = '0;
        other_size_z = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        own_ext[0]   = 256;
        own_ext[1]   = 256;
        own_ext[2]   = 256;
        push_step    = 3;
        push_limit   = 10240;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_wide_boxes();
        test_zero_step();
        test_limit_below_step();
        test_random_sweep();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_placements.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_placements.size());
            mismatch_count++;
        end
        $display("Checked %0d result transactions across %0d register settings.",
                 results_seen, settings_used);
        $display("Outcomes: %0d clear at start, %0d pushed clear, %0d left at the limit.",
                 clear_seen, pushed_seen, limit_seen);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/aop_pkg.sv
src/aop_seq.sv
src/aop_dp.sv
src/aabb_overlap_pushout_search.sv
tb/tb.sv
